>>> sv/pwma_pkg.sv
package pwma_pkg;

  localparam int TS_W        = 32;
  localparam int KEPT_W      = 15;
  localparam int LIMIT_W     = 16;
  localparam int CHG_W       = 16;

  // Window depth; must be a power of two (pointer wraps, average is a shift).
  localparam int WINDOW_SIZE = 8;
  localparam int WIN_LOG     = $clog2(WINDOW_SIZE);
  localparam int PTR_W       = WIN_LOG;
  localparam int SUM_W       = KEPT_W + WIN_LOG;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30000);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(32768);

  // Event kinds carried on the input tuser bit.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_END   = 1'b1;

  // Sample handed from the edge stage to the averaging stage.
  typedef struct packed {
    logic [PTR_W-1:0]  addr;
    logic [KEPT_W-1:0] kept;
    logic              rej;
  } sample_t;

endpackage

>>> sv/pwma_ram.sv
module pwma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/pwma_front.sv
// Edge stage: start-time capture, width, reject test, window pointer.
module pwma_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 acc,
  input  logic                                 func,
  input  logic [pwma_pkg::TS_W-1:0]            timestamp,
  input  logic                                 cfg_wr,
  input  logic [pwma_pkg::LIMIT_W-1:0]         cfg_value,
  output logic                                 issue,
  output pwma_pkg::sample_t                    sample
);

  logic                             armed;
  logic [pwma_pkg::TS_W-1:0]        start_time;
  logic [pwma_pkg::KEPT_W-1:0]      last_kept;
  logic [pwma_pkg::PTR_W-1:0]       oldest;
  logic [pwma_pkg::LIMIT_W-1:0]     reject_limit;

  logic [pwma_pkg::TS_W-1:0]        width;
  logic [pwma_pkg::LIMIT_W-1:0]     lim_eff;
  logic                             rej;
  logic [pwma_pkg::KEPT_W-1:0]      kept;

  always_comb begin
    width   = timestamp - start_time;
    lim_eff = (reject_limit > pwma_pkg::LIMIT_CAP) ? pwma_pkg::LIMIT_CAP : reject_limit;
    rej     = (|width[pwma_pkg::TS_W-1:pwma_pkg::LIMIT_W]) ||
              (width[pwma_pkg::LIMIT_W-1:0] >= lim_eff);
    kept    = rej ? last_kept : width[pwma_pkg::KEPT_W-1:0];
    issue   = acc && (func == pwma_pkg::FUNC_END) && armed;
    sample.addr = oldest;
    sample.kept = kept;
    sample.rej  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      start_time   <= '0;
      last_kept    <= '0;
      oldest       <= '0;
      reject_limit <= pwma_pkg::LIMIT_RESET;
    end else begin
      if (cfg_wr) begin
        reject_limit <= cfg_value;
      end
      if (acc && (func == pwma_pkg::FUNC_START)) begin
        start_time <= timestamp;
        armed      <= 1'b1;
      end else if (issue) begin
        armed     <= 1'b0;
        last_kept <= kept;
        oldest    <= oldest + pwma_pkg::PTR_W'(1);
      end
    end
  end

endmodule

>>> sv/pwma_avg.sv
// Averaging stage: window RAM read-modify-write, running sum, output register.
module pwma_avg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              issue,
  input  pwma_pkg::sample_t                 sample,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pwma_pkg::KEPT_W-1:0]       out_kept,
  output logic                              out_rej,
  output logic [pwma_pkg::KEPT_W-1:0]       out_avg,
  output logic [pwma_pkg::CHG_W-1:0]        out_chg
);

  logic                                 s1_v;
  pwma_pkg::sample_t                    s1;
  logic                                 s1_adv;
  logic [pwma_pkg::WINDOW_SIZE-1:0]     vld;
  logic [pwma_pkg::SUM_W-1:0]           window_sum;
  logic [pwma_pkg::KEPT_W-1:0]          previous_average;

  logic [pwma_pkg::KEPT_W-1:0]          rd_data;
  logic [pwma_pkg::KEPT_W-1:0]          old;
  logic [pwma_pkg::SUM_W-1:0]           sum_next;
  logic [pwma_pkg::KEPT_W-1:0]          avg_next;
  logic [pwma_pkg::CHG_W-1:0]           chg_next;

  // Reads go out with the sample; the write-back lands as the sample leaves s1.
  // The next read is always to the following entry, so they never collide.
  pwma_ram #(
    .WIDTH (pwma_pkg::KEPT_W),
    .DEPTH (pwma_pkg::WINDOW_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.addr),
    .wr_data (s1.kept),
    .rd_en   (issue),
    .rd_addr (sample.addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_adv   = s1_v && (!out_valid || out_ready);
    ready    = !s1_v || s1_adv;
    old      = vld[s1.addr] ? rd_data : '0;
    sum_next = window_sum - pwma_pkg::SUM_W'(old) + pwma_pkg::SUM_W'(s1.kept);
    avg_next = sum_next[pwma_pkg::SUM_W-1:pwma_pkg::WIN_LOG];
    chg_next = pwma_pkg::CHG_W'(previous_average) - pwma_pkg::CHG_W'(avg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v             <= 1'b0;
      out_valid        <= 1'b0;
      vld              <= '0;
      window_sum       <= '0;
      previous_average <= '0;
    end else begin
      if (issue) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        out_valid        <= 1'b1;
        vld[s1.addr]     <= 1'b1;
        window_sum       <= sum_next;
        previous_average <= avg_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= sample;
    end
    if (s1_adv) begin
      out_kept <= s1.kept;
      out_rej  <= s1.rej;
      out_avg  <= avg_next;
      out_chg  <= chg_next;
    end
  end

endmodule

>>> sv/pulse_width_moving_average.sv
// Pulse width moving average.
// Input stream: one transaction per echo edge. tuser is the edge kind (start
// or end), tdata the 32-bit timestamp taken at the edge. A start edge arms the
// block; an end edge while armed yields one result transaction, any other end
// edge yields nothing.
// Output stream: tuser is the reject flag, tdata carries kept sample, window
// average and average change (previous minus new).
// Config channel: one write sets the 16-bit reject limit (reset 30000);
// write only while the block is idle. cfg_ready is always high.
// Throughput: one input transaction per cycle while the output is not stalled.
// The edge that accepts an armed end edge issues the window RAM read and loads
// the RAM stage; the sum update then lands in the output register, which raises
// m_axis_tvalid and holds the result transaction until it is taken.
// The window lives in an 8-entry RAM; per-entry valid bits cleared at reset
// make unwritten entries read as zero, so no clearing pass is needed.
// Reset (rst, synchronous): disarms, clears sum and averages, drops any
// pending result; s_axis_tready is low while rst is high.
// A stalled receiver holds the output register; one more result waits in the
// RAM stage, after which s_axis_tready drops until the output is taken.
module pulse_width_moving_average (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] timestamp
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [14:0] kept_sample, [29:15] window_average,
                                      // [45:30] average_change, [47:46] zero
  output logic        m_axis_tuser,   // [0] rejected
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // [15:0] reject_limit
);

  logic                            avg_ready;
  logic                            acc;
  logic                            issue;
  pwma_pkg::sample_t               sample;
  logic [pwma_pkg::KEPT_W-1:0]     out_kept;
  logic [pwma_pkg::KEPT_W-1:0]     out_avg;
  logic [pwma_pkg::CHG_W-1:0]      out_chg;

  assign s_axis_tready = !rst && avg_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Edge capture and reject decision; issues the window RAM read.
  pwma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .func      (s_axis_tuser),
    .timestamp (s_axis_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .issue     (issue),
    .sample    (sample)
  );

  // Running sum over the window and the output register.
  pwma_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .sample    (sample),
    .ready     (avg_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kept  (out_kept),
    .out_rej   (m_axis_tuser),
    .out_avg   (out_avg),
    .out_chg   (out_chg)
  );

  assign m_axis_tdata = {2'b00, out_chg, out_avg, out_kept};

endmodule

>>> sv/pwma_checker.sv
module pwma_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // A fresh result follows an accepted end edge.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser, 2))
    else $error("result without matching end edge");

  // Config channel never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind pulse_width_moving_average pwma_checker u_pwma_checker (.*);

>>> tb/tb_pulse_width_moving_average.sv
module tb_pulse_width_moving_average;

  // One averaged result as it should leave the block.
  typedef struct packed {
    logic [pwma_pkg::KEPT_W-1:0] kept;
    logic                        rej;
    logic [pwma_pkg::KEPT_W-1:0] avg;
    logic [pwma_pkg::CHG_W-1:0]  change;
  } echo_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] timestamp
  logic        s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [14:0] kept_sample, [29:15] window_average,
                               // [45:30] average_change, [47:46] zero
  logic        m_axis_tuser;   // [0] rejected
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;       // [15:0] reject_limit

  pulse_width_moving_average dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Shadow of the block: arm flag, latched start, window ring and running sum.
  logic                           mdl_armed;
  logic [pwma_pkg::TS_W-1:0]      mdl_start;
  logic [pwma_pkg::KEPT_W-1:0]    mdl_window [pwma_pkg::WINDOW_SIZE];
  logic [pwma_pkg::SUM_W-1:0]     mdl_sum;
  logic [pwma_pkg::KEPT_W-1:0]    mdl_prev_avg;
  int                             mdl_ptr;
  logic [pwma_pkg::LIMIT_W-1:0]   mdl_limit;

  echo_result_t pending_averages [$];   // predicted, not yet seen on m_axis

  int  items_accepted;
  int  results_checked;
  int  limits_written;
  int  rejects_predicted;
  int  failures;
  bit  no_gaps;          // both sides stream without random idles
  int  rx_hold_left;     // receiver hold-off request, counted down by receiver

  // 10 time unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Width measurement, rejection and window update for one edge transaction.
  // Returns 1 when the edge closes an armed pulse and so yields a result.
  function automatic bit measure_echo(input logic fn,
                                      input logic [pwma_pkg::TS_W-1:0] ts,
                                      output echo_result_t res);
    logic [pwma_pkg::TS_W-1:0]    width;
    logic [pwma_pkg::LIMIT_W-1:0] lim;
    logic [pwma_pkg::KEPT_W-1:0]  kept;
    logic [pwma_pkg::KEPT_W-1:0]  avg;
    int                           newest;
    bit                           rej;
    res = '0;
    if (fn == pwma_pkg::FUNC_START) begin
      // start edge always (re)latches and arms
      mdl_start = ts;
      mdl_armed = 1'b1;
      return 1'b0;
    end
    if (!mdl_armed) return 1'b0;   // stray end edge: nothing changes
    mdl_armed = 1'b0;
    width  = ts - mdl_start;       // wraps modulo 2^32
    lim    = (mdl_limit > pwma_pkg::LIMIT_CAP) ? pwma_pkg::LIMIT_CAP : mdl_limit;
    newest = (mdl_ptr + pwma_pkg::WINDOW_SIZE - 1) % pwma_pkg::WINDOW_SIZE;
    rej    = !(width < pwma_pkg::TS_W'(lim));
    kept   = rej ? mdl_window[newest] : width[pwma_pkg::KEPT_W-1:0];
    mdl_sum = mdl_sum - pwma_pkg::SUM_W'(mdl_window[mdl_ptr]) + pwma_pkg::SUM_W'(kept);
    mdl_window[mdl_ptr] = kept;
    mdl_ptr = (mdl_ptr + 1) % pwma_pkg::WINDOW_SIZE;
    avg = pwma_pkg::KEPT_W'(mdl_sum / pwma_pkg::WINDOW_SIZE);
    res.kept   = kept;
    res.rej    = rej;
    res.avg    = avg;
    res.change = pwma_pkg::CHG_W'(mdl_prev_avg) - pwma_pkg::CHG_W'(avg);
    mdl_prev_avg = avg;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // Sends one edge transaction; enters and leaves at a falling edge.
  task automatic send_echo_edge(input logic fn, input logic [pwma_pkg::TS_W-1:0] ts);
    echo_result_t res;
    bit           ignored;
    while (!no_gaps && $urandom_range(99) < 16) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = fn;
    s_axis_tdata  = ts;
    do @(posedge clk); while (!s_axis_tready);
    ignored = (fn == pwma_pkg::FUNC_END) && !mdl_armed;
    if (measure_echo(fn, ts, res)) begin
      pending_averages.push_back(res);
      if (res.rej) rejects_predicted++;
    end
    if (!ignored) items_accepted++;
    @(negedge clk);
  endtask

  task automatic send_pulse(input logic [pwma_pkg::TS_W-1:0] start_ts,
                            input logic [pwma_pkg::TS_W-1:0] width);
    send_echo_edge(pwma_pkg::FUNC_START, start_ts);
    send_echo_edge(pwma_pkg::FUNC_END, start_ts + width);
  endtask

  // Sender stops, then waits for every predicted result plus the pipe latency.
  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Limit writes only happen with the block drained.
  task automatic write_reject_limit(input logic [pwma_pkg::LIMIT_W-1:0] value);
    wait_for_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    mdl_limit = value;
    limits_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Fresh window after reset: stray end, first width rejected, limit boundary.
  task automatic test_after_reset();
    send_echo_edge(pwma_pkg::FUNC_END, 32'h0000_1234);   // unarmed, no result
    send_pulse(32'h0000_0000, 32'd50000);           // rejected, repeats reset zero
    send_pulse(32'h1000_0000, 32'd29999);           // just under the limit
    send_pulse(32'h2000_0000, 32'd30000);           // at the limit: repeats 29999
  endtask

  task automatic test_edge_cases();
    send_echo_edge(pwma_pkg::FUNC_START, 32'h0000_0100);  // start, then a start while armed re-latches
    send_echo_edge(pwma_pkg::FUNC_START, 32'h0000_0200);
    send_echo_edge(pwma_pkg::FUNC_END,   32'h0000_0250);
    send_pulse(32'hFFFF_FFFF, 32'h0000_0020);       // timestamp wrap
    send_echo_edge(pwma_pkg::FUNC_END, 32'hFFFF_FFFF);    // end after disarm
    send_pulse(32'h0000_0001, 32'hFFFF_FFFF);       // widest difference
  endtask

  task automatic test_reject_limits();
    write_reject_limit(16'h0000);                   // everything rejected
    send_pulse(32'h0000_0010, 32'd0);
    write_reject_limit(16'h0001);                   // only zero width passes
    send_pulse(32'h0000_0020, 32'd0);
    send_pulse(32'h0000_0030, 32'd1);
    write_reject_limit(16'hFFFF);                   // clamps to 32768
    send_pulse(32'h8000_0000, 32'd32767);
    send_pulse(32'h8000_1000, 32'd32768);
    write_reject_limit(pwma_pkg::LIMIT_RESET);
  endtask

  // Phases of random pulses, each under its own reject limit.
  task automatic test_random_pulses(input int target);
    int                        phase;
    int                        phase_end;
    int                        sel;
    int                        lim_eff;
    logic [pwma_pkg::TS_W-1:0] width;
    phase = 0;
    while (items_accepted < target) begin
      case ($urandom_range(5))
        0:       write_reject_limit(16'hFFFF);
        1:       write_reject_limit(pwma_pkg::LIMIT_CAP);
        2:       write_reject_limit(pwma_pkg::LIMIT_W'($urandom_range(200, 1)));
        3:       write_reject_limit(pwma_pkg::LIMIT_W'($urandom_range(32768, 1000)));
        4:       write_reject_limit(pwma_pkg::LIMIT_W'($urandom));
        default: write_reject_limit(pwma_pkg::LIMIT_RESET);
      endcase
      no_gaps   = (phase == 2);                     // one long stretch without idles
      lim_eff   = (mdl_limit > pwma_pkg::LIMIT_CAP) ? int'(pwma_pkg::LIMIT_CAP)
                                                    : int'(mdl_limit);
      phase_end = items_accepted + 55;
      while (items_accepted < phase_end) begin
        sel = $urandom_range(99);
        if (sel < 6) begin
          send_echo_edge(pwma_pkg::FUNC_END, $urandom);     // noise: stray end
        end else if (sel < 10) begin
          send_echo_edge(pwma_pkg::FUNC_START, $urandom);   // noise: orphan start
        end else begin
          sel = $urandom_range(99);
          if (sel < 55)      width = (lim_eff > 0) ? $urandom_range(lim_eff - 1, 0) : 0;
          else if (sel < 70) width = lim_eff + $urandom_range(2) - 1;
          else if (sel < 85) width = $urandom_range(32767);
          else               width = $urandom;
          send_pulse($urandom, width);
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Receiver holds off while the sender keeps streaming, then a full drain.
  task automatic test_backpressure();
    int k;
    no_gaps      = 1'b1;
    rx_hold_left = 60;
    for (k = 0; k < 20; k++) send_pulse($urandom, $urandom_range(29999));
    wait_for_results();
    no_gaps = 1'b0;
    for (k = 0; k < 10; k++) send_pulse($urandom, $urandom_range(40000));
  endtask

  // Receiver: random idles, or a counted hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_left--;
      end else if (no_gaps) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 16);
      end
    end
  end

  // Result checker: each output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin : check_result
      echo_result_t got;
      echo_result_t want;
      got.kept   = m_axis_tdata[14:0];
      got.avg    = m_axis_tdata[29:15];
      got.change = m_axis_tdata[45:30];
      got.rej    = m_axis_tuser;
      if (pending_averages.size() == 0) begin
        note_failure("result transaction with no pulse pending");
      end else begin
        want = pending_averages.pop_front();
        results_checked++;
        if (got !== want || m_axis_tdata[47:46] !== 2'b00)
          note_failure($sformatf({"mismatch kept %0d/%0d rej %0d/%0d avg %0d/%0d ",
                                  "change %0d/%0d pad %0d (expected/actual)"},
                                 want.kept, got.kept, want.rej, got.rej,
                                 want.avg, got.avg, $signed(want.change),
                                 $signed(got.change), m_axis_tdata[47:46]));
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pwma_pkg::FUNC_START;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    rx_hold_left  = 0;
    mdl_armed     = 1'b0;
    mdl_start     = '0;
    mdl_sum       = '0;
    mdl_prev_avg  = '0;
    mdl_ptr       = 0;
    mdl_limit     = pwma_pkg::LIMIT_RESET;
    for (k = 0; k < pwma_pkg::WINDOW_SIZE; k++) mdl_window[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_after_reset();
    test_edge_cases();
    test_reject_limits();
    test_random_pulses(440);
    test_backpressure();
    wait_for_results();

    $display("Covered %0d edge transactions, %0d results checked, %0d rejected widths,",
             items_accepted, results_checked, rejects_predicted);
    $display("%0d reject limit writes, receiver hold-off and full drain.", limits_written);
    if (failures == 0 && pending_averages.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
